FILE: sv/fdsd_pkg.sv
package fdsd_pkg;

  // field widths
  localparam int unsigned CmdW   = 3;
  localparam int unsigned ValueW = 16;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned SegW   = 8;
  localparam int unsigned SelW   = 4;
  localparam int unsigned Digits = 4;

  // command codes, the two top codes do nothing
  typedef enum logic [CmdW-1:0] {
    CMD_TICK     = 3'd0,
    CMD_RAW      = 3'd1,
    CMD_HEX_BYTE = 3'd2,
    CMD_HEX_WORD = 3'd3,
    CMD_DEC_BYTE = 3'd4,
    CMD_DEC_WORD = 3'd5
  } cmd_e;

  typedef logic [SegW-1:0] seg_t;

  localparam seg_t BlankSeg = 8'hFF;
  localparam logic [SelW-1:0] AllOff = 4'hF;

  // reciprocal multipliers for exact division of a 16-bit value
  localparam int unsigned RecipW   = 17;
  localparam int unsigned ProdW    = ValueW + RecipW;
  localparam logic [RecipW-1:0] Recip10    = 17'd52429;
  localparam logic [RecipW-1:0] Recip100   = 17'd83887;
  localparam logic [RecipW-1:0] Recip1000  = 17'd67109;
  localparam logic [RecipW-1:0] Recip10000 = 17'd107375;
  localparam int unsigned Shift10    = 19;
  localparam int unsigned Shift100   = 23;
  localparam int unsigned Shift1000  = 26;
  localparam int unsigned Shift10000 = 30;

  // quotient widths for a 16-bit dividend
  localparam int unsigned Q1W = 13;
  localparam int unsigned Q2W = 10;
  localparam int unsigned Q3W = 7;
  localparam int unsigned Q4W = 3;

  // active-low font for one nibble
  function automatic seg_t glyph(input logic [3:0] nib);
    seg_t pat;
    case (nib)
      4'h0: pat = 8'h50;
      4'h1: pat = 8'h5F;
      4'h2: pat = 8'h32;
      4'h3: pat = 8'h16;
      4'h4: pat = 8'h1D;
      4'h5: pat = 8'h94;
      4'h6: pat = 8'h90;
      4'h7: pat = 8'h5E;
      4'h8: pat = 8'h10;
      4'h9: pat = 8'h14;
      4'hA: pat = 8'h18;
      4'hB: pat = 8'h91;
      4'hC: pat = 8'hF0;
      4'hD: pat = 8'h13;
      4'hE: pat = 8'hB0;
      4'hF: pat = 8'hB8;
      default: pat = BlankSeg;
    endcase
    return pat;
  endfunction

endpackage

FILE: sv/four_digit_seven_segment_driver_top.sv
// channel  | valid       | stall        | payload
// ---------+-------------+--------------+-----------------------------------------------
// in       | in_valid_i  | in_stall_o   | command_i, value_i, digit_index_i,
//          |             |              | segment_pattern_i
// out      | out_valid_o | out_stall_i  | segment_lines_o, digit_select_o
//
// one item per cycle while the output is not stalled; a result passes through the quotient
// register of stage one and then the pattern and drive registers of stage two
// the decimal quotients come from one reciprocal multiplier each, in parallel
// reset clears the patterns to blank, the scan to digit 0 and the drive to all off
// an output stall holds the drive and backs up through the single input stage
module four_digit_seven_segment_driver_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [fdsd_pkg::CmdW-1:0]     command_i,
  input  logic [fdsd_pkg::ValueW-1:0]   value_i,
  input  logic [fdsd_pkg::IdxW-1:0]     digit_index_i,
  input  logic [fdsd_pkg::SegW-1:0]     segment_pattern_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fdsd_pkg::SegW-1:0]     segment_lines_o,
  output logic [fdsd_pkg::SelW-1:0]     digit_select_o
);
  import fdsd_pkg::*;

  // stage one: item and quotients
  logic                 s1_valid_q;
  logic [CmdW-1:0]      s1_cmd_q;
  logic [ValueW-1:0]    s1_val_q;
  logic [IdxW-1:0]      s1_idx_q;
  seg_t                 s1_pat_q;
  logic [Q1W-1:0]       s1_q1_q;
  logic [Q2W-1:0]       s1_q2_q;
  logic [Q3W-1:0]       s1_q3_q;
  logic [Q4W-1:0]       s1_q4_q;

  // stage two: display state and result
  seg_t                 pat_q [Digits];
  seg_t                 pat_d [Digits];
  logic [IdxW-1:0]      scan_q, scan_d;
  seg_t                 seg_q, seg_d;
  logic [SelW-1:0]      sel_q, sel_d;
  logic                 out_valid_q;

  logic                 in_fire;
  logic                 s1_stall;
  logic                 s1_fire;

  logic [ValueW-1:0]    div_x;
  logic [ProdW-1:0]     prod10, prod100, prod1000, prod10000;

  logic [ValueW-1:0]    x2;
  logic [ValueW-1:0]    rem0;
  logic [Q1W-1:0]       rem1;
  logic [Q2W-1:0]       rem2;
  logic [Q3W-1:0]       rem3;
  seg_t                 g0, g1, g2, g3;

  // handshake
  assign s1_stall   = out_valid_q && out_stall_i;
  assign s1_fire    = s1_valid_q && !s1_stall;
  assign in_stall_o = s1_valid_q && s1_stall;
  assign in_fire    = in_valid_i && !in_stall_o;

  // dividend: low byte for the decimal byte mode
  assign div_x = (command_i == CMD_DEC_BYTE) ? {8'h00, value_i[7:0]} : value_i;

  // reciprocal products, one per decimal place
  assign prod10    = ProdW'(div_x) * ProdW'(Recip10);
  assign prod100   = ProdW'(div_x) * ProdW'(Recip100);
  assign prod1000  = ProdW'(div_x) * ProdW'(Recip1000);
  assign prod10000 = ProdW'(div_x) * ProdW'(Recip10000);

  // stage one valid, fills whenever the stage is empty or moving on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_fire;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q <= command_i;
      s1_val_q <= value_i;
      s1_idx_q <= digit_index_i;
      s1_pat_q <= segment_pattern_i;
      s1_q1_q  <= Q1W'(prod10 >> Shift10);
      s1_q2_q  <= Q2W'(prod100 >> Shift100);
      s1_q3_q  <= Q3W'(prod1000 >> Shift1000);
      s1_q4_q  <= Q4W'(prod10000 >> Shift10000);
    end
  end

  // decimal digits from neighbouring quotients
  assign x2   = (s1_cmd_q == CMD_DEC_BYTE) ? {8'h00, s1_val_q[7:0]} : s1_val_q;
  assign rem0 = x2 - (ValueW'(s1_q1_q) * ValueW'(10));
  assign rem1 = s1_q1_q - Q1W'(Q1W'(s1_q2_q) * Q1W'(10));
  assign rem2 = s1_q2_q - Q2W'(Q2W'(s1_q3_q) * Q2W'(10));
  assign rem3 = s1_q3_q - Q3W'(Q3W'(s1_q4_q) * Q3W'(10));

  // font lookups, shared by hex and decimal modes
  always_comb begin
    if (s1_cmd_q == CMD_HEX_WORD || s1_cmd_q == CMD_HEX_BYTE) begin
      g0 = glyph(s1_val_q[15:12]);
      g1 = glyph(s1_val_q[11:8]);
      g2 = glyph(s1_val_q[7:4]);
      g3 = glyph(s1_val_q[3:0]);
    end else begin
      g0 = glyph(rem3[3:0]);
      g1 = glyph(rem2[3:0]);
      g2 = glyph(rem1[3:0]);
      g3 = glyph(rem0[3:0]);
    end
  end

  // next display state for the item in stage one
  always_comb begin
    pat_d  = pat_q;
    scan_d = scan_q;
    seg_d  = seg_q;
    sel_d  = sel_q;
    case (s1_cmd_q)
      CMD_TICK: begin
        seg_d  = pat_q[scan_q];
        sel_d  = ~(SelW'(1) << scan_q);
        scan_d = scan_q + IdxW'(1);
      end
      CMD_RAW: begin
        pat_d[s1_idx_q] = s1_pat_q;
      end
      CMD_HEX_BYTE: begin
        pat_d[0] = BlankSeg;
        pat_d[1] = BlankSeg;
        pat_d[2] = g2;
        pat_d[3] = g3;
      end
      CMD_HEX_WORD, CMD_DEC_WORD: begin
        pat_d[0] = g0;
        pat_d[1] = g1;
        pat_d[2] = g2;
        pat_d[3] = g3;
      end
      CMD_DEC_BYTE: begin
        pat_d[0] = BlankSeg;
        pat_d[1] = g1;
        pat_d[2] = g2;
        pat_d[3] = g3;
      end
      default: begin
      end
    endcase
  end

  // display state, drive and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Digits; i++) begin
        pat_q[i] <= BlankSeg;
      end
      scan_q      <= '0;
      seg_q       <= BlankSeg;
      sel_q       <= AllOff;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        pat_q  <= pat_d;
        scan_q <= scan_d;
        seg_q  <= seg_d;
        sel_q  <= sel_d;
      end
      if (!s1_stall) begin
        out_valid_q <= s1_fire;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign segment_lines_o = seg_q;
  assign digit_select_o  = sel_q;

`ifndef SYNTHESIS
  // a tick always enables exactly one digit
  a_tick_one_cold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_cmd_q == CMD_TICK |=> $onehot(~digit_select_o))
    else $error("tick did not select exactly one digit");

  // only a tick changes the drive
  a_update_keeps_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && s1_cmd_q != CMD_TICK |=> $stable(segment_lines_o) && $stable(digit_select_o))
    else $error("drive changed on a non-tick item");

  // the scan moves only on a tick
  a_scan_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && s1_cmd_q == CMD_TICK) |=> $stable(scan_q))
    else $error("scan position moved without a tick");

  // a stalled result keeps its drive
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(seg_q) && $stable(sel_q))
    else $error("stalled result changed");
`endif

endmodule

FILE: test/four_digit_seven_segment_driver_top_tb.sv
`timescale 1ns / 100ps

module four_digit_seven_segment_driver_top_tb;
  import fdsd_pkg::*;

  // the two command codes that the block ignores
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned TailCycles = 8;

  // font for nibbles 0 to F, nibble 0 in the low byte
  localparam logic [127:0] FontLut = {
    8'hB8, 8'hB0, 8'h13, 8'hF0, 8'h91, 8'h18, 8'h14, 8'h10,
    8'h5E, 8'h90, 8'h94, 8'h1D, 8'h16, 8'h32, 8'h5F, 8'h50
  };

  typedef struct packed {
    seg_t            seg;
    logic [SelW-1:0] sel;
  } drive_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CmdW-1:0]   command_i = CMD_TICK;
  logic [ValueW-1:0] value_i = '0;
  logic [IdxW-1:0]   digit_index_i = '0;
  logic [SegW-1:0]   segment_pattern_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [SegW-1:0]   segment_lines_o;
  logic [SelW-1:0]   digit_select_o;

  // shadow copy of the display state
  seg_t            shadow_pat [Digits];
  logic [IdxW-1:0] shadow_scan;
  seg_t            shadow_seg;
  logic [SelW-1:0] shadow_sel;

  drive_t drive_q [$];
  drive_t want_drive;

  bit          send_bursts_on = 1'b1;
  bit          stall_bursts_on = 1'b1;
  int unsigned mismatches = 0;
  int unsigned items_sent = 0;
  int unsigned ticks_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  four_digit_seven_segment_driver_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .value_i           (value_i),
    .digit_index_i     (digit_index_i),
    .segment_pattern_i (segment_pattern_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .segment_lines_o   (segment_lines_o),
    .digit_select_o    (digit_select_o)
  );

  // clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               drive_q.size());
      $display("four_digit_seven_segment_driver_top_tb NOT OK");
      $finish;
    end
  end

  function automatic seg_t font_of(input logic [3:0] nib);
    return FontLut[nib*8 +: 8];
  endfunction

  // values biased towards the ends of the range
  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return ValueW'($urandom_range(0, 255));
      3: return ValueW'($urandom_range(9990, 10010));
      default: return ValueW'($urandom_range(0, 65535));
    endcase
  endfunction

  // update the shadow state and queue the drive the item returns
  task automatic predict_drive(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                               input logic [IdxW-1:0] idx, input seg_t pat);
    logic [7:0] lo;
    int unsigned b;
    int unsigned w;
    lo = val[7:0];
    b = lo;
    w = val;
    case (cmd)
      CMD_TICK: begin
        shadow_seg  = shadow_pat[shadow_scan];
        shadow_sel  = ~(4'b0001 << shadow_scan);
        shadow_scan = shadow_scan + 1'b1;
        ticks_sent++;
      end
      CMD_RAW: shadow_pat[idx] = pat;
      CMD_HEX_BYTE: begin
        shadow_pat[0] = BlankSeg;
        shadow_pat[1] = BlankSeg;
        shadow_pat[2] = font_of(lo[7:4]);
        shadow_pat[3] = font_of(lo[3:0]);
      end
      CMD_HEX_WORD: begin
        shadow_pat[0] = font_of(val[15:12]);
        shadow_pat[1] = font_of(val[11:8]);
        shadow_pat[2] = font_of(val[7:4]);
        shadow_pat[3] = font_of(val[3:0]);
      end
      CMD_DEC_BYTE: begin
        shadow_pat[0] = BlankSeg;
        shadow_pat[1] = font_of(4'(b / 100));
        shadow_pat[2] = font_of(4'((b / 10) % 10));
        shadow_pat[3] = font_of(4'(b % 10));
      end
      CMD_DEC_WORD: begin
        // ten-thousands digit is not shown
        shadow_pat[0] = font_of(4'((w / 1000) % 10));
        shadow_pat[1] = font_of(4'((w / 100) % 10));
        shadow_pat[2] = font_of(4'((w / 10) % 10));
        shadow_pat[3] = font_of(4'(w % 10));
      end
      default: ;
    endcase
    drive_q.push_back('{shadow_seg, shadow_sel});
  endtask

  // offer one item, with an occasional idle burst in front of it
  task automatic send_item(input logic [CmdW-1:0] cmd, input logic [ValueW-1:0] val,
                           input logic [IdxW-1:0] idx, input seg_t pat);
    if (send_bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    command_i         <= cmd;
    value_i           <= val;
    digit_index_i     <= idx;
    segment_pattern_i <= pat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
    predict_drive(cmd, val, idx, pat);
  endtask

  // command with random content in every other field
  task automatic send_cmd(input logic [CmdW-1:0] cmd);
    send_item(cmd, pick_value(), IdxW'($urandom_range(0, 3)), SegW'($urandom_range(0, 255)));
  endtask

  // hold the input idle until every queued drive has come back
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result: seg %h sel %h", segment_lines_o, digit_select_o);
      end else begin
        want_drive = drive_q.pop_front();
        results_seen++;
        if (segment_lines_o !== want_drive.seg || digit_select_o !== want_drive.sel) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("result %0d mismatch: seg exp %h got %h, sel exp %h got %h",
                     results_seen, want_drive.seg, segment_lines_o, want_drive.sel,
                     digit_select_o);
        end
      end
    end
  end

  // receiver stall bursts
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && stall_bursts_on && $urandom_range(0, 6) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // blank drive after reset, first digit select, ignored codes
  task automatic test_reset_drive();
    send_cmd(CMD_TICK);
    send_cmd(CmdSpareLo);
    send_cmd(CmdSpareHi);
  endtask

  // raw writes at pattern extremes, then scan through the wrap
  task automatic test_raw_writes();
    send_item(CMD_RAW, 16'hFFFF, 2'd1, 8'h00);
    send_item(CMD_RAW, 16'h0000, 2'd2, 8'hFF);
    send_item(CMD_RAW, 16'h5A5A, 2'd3, 8'hA5);
    send_item(CMD_RAW, 16'hA5A5, 2'd0, 8'h5A);
    repeat (4) send_cmd(CMD_TICK);
  endtask

  // hex byte ignores the high byte, hex word at both ends
  task automatic test_hex_modes();
    send_item(CMD_HEX_BYTE, 16'hABF0, 2'd3, 8'h00);
    repeat (4) send_cmd(CMD_TICK);
    send_item(CMD_HEX_WORD, 16'hFFFF, 2'd0, 8'hFF);
    send_cmd(CMD_TICK);
    send_item(CMD_HEX_WORD, 16'h0000, 2'd0, 8'hFF);
    send_cmd(CMD_TICK);
  endtask

  // decimal modes, including the dropped ten-thousands digit
  task automatic test_decimal_modes();
    send_item(CMD_DEC_BYTE, 16'hFFFF, 2'd0, 8'h00);
    repeat (2) send_cmd(CMD_TICK);
    send_item(CMD_DEC_WORD, 16'd65535, 2'd3, 8'hFF);
    send_cmd(CMD_TICK);
    send_item(CMD_DEC_WORD, 16'd10000, 2'd1, 8'h00);
    send_cmd(CMD_TICK);
    send_item(CMD_DEC_BYTE, 16'h0000, 2'd2, 8'h00);
  endtask

  // updates followed by a short scan, with raw writes and noise mixed in
  task automatic test_random_traffic(input int unsigned count);
    int unsigned done_items;
    logic [CmdW-1:0] cmd;
    done_items = 0;
    while (done_items < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          send_cmd(CmdW'($urandom_range(CMD_HEX_BYTE, CMD_DEC_WORD)));
          done_items++;
          repeat ($urandom_range(1, 6)) begin
            send_cmd(CMD_TICK);
            done_items++;
          end
        end
        7, 8: begin
          send_cmd(CMD_RAW);
          done_items++;
        end
        default: begin
          cmd = CmdW'($urandom_range(0, 7));
          send_cmd(cmd);
          if (cmd != CmdSpareLo && cmd != CmdSpareHi) done_items++;
        end
      endcase
    end
  endtask

  // sender waits for the pipeline to empty before carrying on
  task automatic test_pause_for_results();
    send_cmd(CMD_HEX_WORD);
    wait_for_results();
    send_cmd(CMD_TICK);
    send_cmd(CMD_TICK);
  endtask

  // back to back traffic with no idling on either side
  task automatic test_steady_stream(input int unsigned count);
    send_bursts_on  = 1'b0;
    stall_bursts_on = 1'b0;
    test_random_traffic(count);
  endtask

  initial begin
    foreach (shadow_pat[k]) shadow_pat[k] = BlankSeg;
    shadow_scan = '0;
    shadow_seg  = BlankSeg;
    shadow_sel  = AllOff;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_drive();
    test_raw_writes();
    test_hex_modes();
    test_decimal_modes();
    test_random_traffic(700);
    test_pause_for_results();
    test_random_traffic(550);
    test_steady_stream(200);

    wait_for_results();
    repeat (TailCycles) @(posedge clk_i);
    if (drive_q.size() != 0) begin
      mismatches += drive_q.size();
      $display("%0d expected results never arrived", drive_q.size());
    end

    $display("sent %0d items (%0d ticks) over all display modes and raw writes", items_sent,
             ticks_sent);
    $display("checked %0d results with input and output stalls, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0) begin
      $display("four_digit_seven_segment_driver_top_tb OK");
    end else begin
      $display("four_digit_seven_segment_driver_top_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/fdsd_pkg.sv
sv/four_digit_seven_segment_driver_top.sv
test/four_digit_seven_segment_driver_top_tb.sv
